// ===== sv/fmg_pkg.sv =====
package fmg_pkg;

	// shape code carried with every result
	typedef enum logic [1:0] {
		KIND_LEFT  = 2'd0,
		KIND_TRI   = 2'd1,
		KIND_TRAP  = 2'd2,
		KIND_RIGHT = 2'd3
	} shape_kind_t;

	// how the grade of a word is formed at the end of the chain
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_ONE  = 2'd1,
		CLS_EDGE = 2'd2
	} grade_cls_t;

	// sideband that travels along the chain with each word
	typedef struct packed {
		shape_kind_t kind;
		grade_cls_t  cls;
	} fmg_tag_t;

	localparam int KIND_W = 2;

endpackage

// ===== sv/fmg_front.sv =====
module fmg_front import fmg_pkg::*; #(
	parameter int VW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [VW-1:0] sample,
	input  logic signed [VW-1:0] break_a,
	input  logic signed [VW-1:0] break_b,
	input  logic signed [VW-1:0] break_c,
	input  logic signed [VW-1:0] break_d,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fmg_tag_t             tag_s1,
	output logic        [VW-1:0] cen_s1,
	output logic        [VW-1:0] rem_s1,
	output logic        [VW-1:0] den_s1
);

	localparam int DW = VW + 1;

	logic signed [DW-1:0] rise_num, rise_den, fall_num, fall_den, cen_sum;
	shape_kind_t          kind;
	grade_cls_t           cls;
	logic                 use_fall;
	logic                 adv;

	// edge differences at full width; only taken when positive and below VW bits
	assign rise_num = DW'(sample) - DW'(break_a);
	assign rise_den = DW'(break_b) - DW'(break_a);
	assign fall_num = DW'(break_d) - DW'(sample);
	assign fall_den = DW'(break_d) - DW'(break_c);
	assign cen_sum  = DW'(break_a) + DW'(break_d);

	// shape selection and range tests
	always_comb begin
		cls      = CLS_ZERO;
		use_fall = 1'b0;
		priority if (break_a == break_b) begin
			kind = KIND_LEFT;
			if (sample <= break_c) begin
				cls = CLS_ONE;
			end else if (sample < break_d) begin
				cls      = CLS_EDGE;
				use_fall = 1'b1;
			end
		end else if (break_b == break_c) begin
			kind = KIND_TRI;
			if (sample == break_b) begin
				cls = CLS_ONE;
			end else if (sample > break_a && sample < break_b) begin
				cls = CLS_EDGE;
			end else if (sample > break_b && sample < break_d) begin
				cls      = CLS_EDGE;
				use_fall = 1'b1;
			end
		end else if (break_c != break_d) begin
			kind = KIND_TRAP;
			if (sample >= break_b && sample <= break_c) begin
				cls = CLS_ONE;
			end else if (sample > break_a && sample < break_b) begin
				cls = CLS_EDGE;
			end else if (sample > break_c && sample < break_d) begin
				cls      = CLS_EDGE;
				use_fall = 1'b1;
			end
		end else begin
			kind = KIND_RIGHT;
			if (sample >= break_b) begin
				cls = CLS_ONE;
			end else if (sample > break_a && sample < break_b) begin
				cls = CLS_EDGE;
			end
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign adv      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= '{kind: kind, cls: cls};
			cen_s1 <= cen_sum[DW-1:1];
			rem_s1 <= use_fall ? fall_num[VW-1:0] : rise_num[VW-1:0];
			den_s1 <= use_fall ? fall_den[VW-1:0] : rise_den[VW-1:0];
		end
	end

endmodule

// ===== sv/fmg_div_cell.sv =====
module fmg_div_cell import fmg_pkg::*; #(
	parameter int VW = 16,
	parameter int QW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fmg_tag_t      in_tag,
	input  logic [VW-1:0] in_cen,
	input  logic [VW-1:0] in_rem,
	input  logic [VW-1:0] in_den,
	input  logic [QW-1:0] in_quo,
	output logic          out_valid,
	input  logic          out_ready,
	output fmg_tag_t      tag_q,
	output logic [VW-1:0] cen_q,
	output logic [VW-1:0] rem_q,
	output logic [VW-1:0] den_q,
	output logic [QW-1:0] quo_q
);

	logic [VW:0] rem2, diff;
	logic        ge;
	logic        adv;

	// one restoring step: shift remainder, try subtracting the divisor
	assign rem2 = {in_rem, 1'b0};
	assign diff = rem2 - {1'b0, in_den};
	assign ge   = rem2 >= {1'b0, in_den};

	assign in_ready = !out_valid || out_ready;
	assign adv      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q <= in_tag;
			cen_q <= in_cen;
			den_q <= in_den;
			rem_q <= ge ? diff[VW-1:0] : rem2[VW-1:0];
			quo_q <= {in_quo[QW-2:0], ge};
		end
	end

endmodule

// ===== sv/fuzzy_membership_grade_unit.sv =====
// Trapezoidal membership grade of a stream of samples.
// Path: an accepted sample passes one classify stage, then one divider cell per
// quotient bit, before it leaves as a result word.
// Throughput: one word per cycle while m_tready is high; every cell has its own valid and closes bubbles.
// Reset: arst_n clears all valid bits and sets the four break points to 0.
module fuzzy_membership_grade_unit import fmg_pkg::*; #(
	parameter int VALUE_WIDTH     = 16,
	parameter int GRADE_FRAC_BITS = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [VALUE_WIDTH-1:0] cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata: sample
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: grade, centroid
	output logic [((GRADE_FRAC_BITS+1+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	// m_tuser: shape_kind
	output logic [KIND_W-1:0]      m_tuser
);

	localparam int VW     = VALUE_WIDTH;
	localparam int QW     = GRADE_FRAC_BITS;
	localparam int GW     = GRADE_FRAC_BITS + 1;
	localparam int OUT_TW = ((GW + VW + 7) / 8) * 8;

	localparam logic [1:0] REG_BREAK_A = 2'd0;
	localparam logic [1:0] REG_BREAK_B = 2'd1;
	localparam logic [1:0] REG_BREAK_C = 2'd2;
	localparam logic [1:0] REG_BREAK_D = 2'd3;

	logic signed [VW-1:0] break_a_q, break_b_q, break_c_q, break_d_q;

	// break point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_a_q <= '0;
			break_b_q <= '0;
			break_c_q <= '0;
			break_d_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BREAK_A: break_a_q <= cfg_data;
				REG_BREAK_B: break_b_q <= cfg_data;
				REG_BREAK_C: break_c_q <= cfg_data;
				REG_BREAK_D: break_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// chain links: index 0 is the classify stage, QW is the last cell
	logic          vld [QW+1];
	logic          rdy [QW+1];
	fmg_tag_t      tag [QW+1];
	logic [VW-1:0] cen [QW+1];
	logic [VW-1:0] rem [QW+1];
	logic [VW-1:0] den [QW+1];
	logic [QW-1:0] quo [QW+1];

	fmg_front #(.VW(VW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata[VW-1:0]),
		.break_a   (break_a_q),
		.break_b   (break_b_q),
		.break_c   (break_c_q),
		.break_d   (break_d_q),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.tag_s1    (tag[0]),
		.cen_s1    (cen[0]),
		.rem_s1    (rem[0]),
		.den_s1    (den[0])
	);
	assign quo[0] = '0;

	// one divider cell per quotient bit
	for (genvar i = 0; i < QW; i++) begin : g_cell
		fmg_div_cell #(.VW(VW), .QW(QW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_tag    (tag[i]),
			.in_cen    (cen[i]),
			.in_rem    (rem[i]),
			.in_den    (den[i]),
			.in_quo    (quo[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.tag_q     (tag[i+1]),
			.cen_q     (cen[i+1]),
			.rem_q     (rem[i+1]),
			.den_q     (den[i+1]),
			.quo_q     (quo[i+1])
		);
	end

	// last cell is the output register; unused remainder is dropped there
	logic [GW-1:0] grade;

	assign rdy[QW]  = m_tready;
	assign m_tvalid = vld[QW];

	always_comb begin
		unique case (tag[QW].cls)
			CLS_ONE:  grade = GW'(1) << QW;
			CLS_EDGE: grade = {1'b0, quo[QW]};
			default:  grade = '0;
		endcase
	end

	assign m_tdata = OUT_TW'({cen[QW], grade});
	assign m_tuser = tag[QW].kind;

endmodule
